>>> rtl/stcp_pkg.sv
// ----------------------------------------------------------------------------
// stcp_pkg
// Shared constants for the stick cartesian-to-polar converter: datapath
// widths, CORDIC arctangent table, inverse gain and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package stcp_pkg;

  // Fraction guard bits carried on x and y through the rotations
  localparam int GuardBits = 16;

  // x/y datapath width: 17-bit folded input, 16 guard bits, CORDIC growth
  localparam int DataW = 36;

  // Angle accumulator width, signed Q.20 (covers pi plus the rotation sum)
  localparam int AngAccW = 24;

  // Arctangent table depth
  localparam int AtanLen = 24;

  // round(atan(2^-i) * 2^20)
  localparam int unsigned AtanQ20 [AtanLen] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  localparam int PiQ20 = 3294199;

  // Inverse CORDIC gain in Q.30: base value plus a tail shrinking by 4 per stage
  localparam int unsigned InvGainQ30  = 652032874;
  localparam int unsigned GainTailQ30 = 434688583;

  // Inverse gain multiply: 30-bit constant, x split into a low and a high part
  localparam int CompW   = 30;
  localparam int SplitW  = 17;
  localparam int ProdLoW = SplitW + CompW;
  localparam int ProdHiW = DataW - 1 - SplitW + CompW;
  localparam int SumW    = ProdHiW + SplitW + 1;
  localparam int MagShift = CompW + GuardBits;

  localparam int MagLimit   = 46341;
  localparam int AngleLimit = 25736;

endpackage : stcp_pkg

`default_nettype wire

>>> rtl/stick_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// stick_cartesian_to_polar
// Thumbstick (x, y) to (magnitude, angle) converter, pipelined CORDIC.
// ----------------------------------------------------------------------------
// Converts one signed 16-bit stick sample per clock, while the output is not
// stalled, into its length in stick counts (truncated, limited to 0..46341)
// and its atan2 angle in signed Q3.13 radians (-pi..pi, with (0,0) giving
// angle 0). The vector is first folded into the right half plane and
// registered on entry. It then passes one register stage per CORDIC
// micro-rotation, one stage of split partial products for the inverse gain,
// and one output stage. Throughput is one transaction per cycle while
// out_ready_i is held high. Every stage carries its own valid bit and only
// holds when the stage after it is full and stalled, so empty slots are
// squeezed out under backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_cartesian_to_polar
  import stcp_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] x_coord_i,
  input  wire logic signed [15:0] y_coord_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [15:0] magnitude_o,
  output logic signed      [15:0] angle_o
);

  localparam int NumIter = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  // Stages 0..NumIter: rotation, NumIter+1: products, NumIter+2: output
  localparam int NumRegs = NumIter + 3;
  localparam int ProdIdx = NumIter + 1;
  localparam int OutIdx  = NumIter + 2;

  localparam logic [CompW-1:0] Comp =
    CompW'(InvGainQ30 + (GainTailQ30 >> (2 * NumIter)));

  localparam logic signed [AngAccW-1:0] PiZ = AngAccW'(PiQ20);

  // --------------------------------------------------------------------------
  // Stage handshake
  // --------------------------------------------------------------------------
  logic [NumRegs-1:0] valid_q;
  logic [NumRegs-1:0] ready;

  always_comb begin
    ready[NumRegs-1] = ~valid_q[NumRegs-1] | out_ready_i;
    for (int k = NumRegs - 2; k >= 0; k--) begin
      ready[k] = ~valid_q[k] | ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumRegs; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = ready[0];

  // --------------------------------------------------------------------------
  // Rotation pipeline
  // --------------------------------------------------------------------------
  logic signed [DataW-1:0]   x_q    [NumIter+1];
  logic signed [DataW-1:0]   y_q    [NumIter+1];
  logic signed [AngAccW-1:0] z_q    [NumIter+1];
  logic                      zero_q [NumIter+1];

  // Fold the left half plane by pi
  logic signed [16:0]        x_fold;
  logic signed [16:0]        y_fold;
  logic signed [AngAccW-1:0] z_init;

  always_comb begin
    if (x_coord_i < 0) begin
      x_fold = -17'(x_coord_i);
      y_fold = -17'(y_coord_i);
      z_init = (y_coord_i >= 0) ? PiZ : -PiZ;
    end else begin
      x_fold = 17'(x_coord_i);
      y_fold = 17'(y_coord_i);
      z_init = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready[0]) begin
      x_q[0]    <= DataW'(x_fold) <<< GuardBits;
      y_q[0]    <= DataW'(y_fold) <<< GuardBits;
      z_q[0]    <= z_init;
      zero_q[0] <= (x_coord_i == 16'sd0) && (y_coord_i == 16'sd0);
    end
  end

  for (genvar g = 0; g < NumIter; g++) begin : g_rot
    localparam logic signed [AngAccW-1:0] AtanStep = AngAccW'(AtanQ20[g]);

    logic signed [DataW-1:0] dx;
    logic signed [DataW-1:0] dy;

    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;

    always_ff @(posedge clk_i) begin
      if (valid_q[g] && ready[g+1]) begin
        zero_q[g+1] <= zero_q[g];
        // Rotate clockwise when y is zero or positive
        if (y_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + AtanStep;
        end else begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - AtanStep;
        end
      end
    end
  end : g_rot

  // --------------------------------------------------------------------------
  // Gain compensation products and angle rounding
  // --------------------------------------------------------------------------
  logic [DataW-2:0]        x_pos;
  logic [ProdLoW-1:0]      prod_lo_d;
  logic [ProdHiW-1:0]      prod_hi_d;
  logic signed [AngAccW:0] z_round;
  logic signed [AngAccW-7:0] z_scaled;
  logic signed [15:0]      ang_d;

  always_comb begin
    x_pos = (x_q[NumIter] < 0) ? '0 : x_q[NumIter][DataW-2:0];
    prod_lo_d = ProdLoW'(x_pos[SplitW-1:0]) * ProdLoW'(Comp);
    prod_hi_d = ProdHiW'(x_pos[DataW-2:SplitW]) * ProdHiW'(Comp);

    // Round half up into Q3.13, then clamp to +-pi; the origin gives angle 0
    z_round  = (AngAccW+1)'(z_q[NumIter]) + (AngAccW+1)'(64);
    z_scaled = z_round[AngAccW:7];
    if (zero_q[NumIter]) begin
      ang_d = '0;
    end else if (z_scaled > (AngAccW-6)'(AngleLimit)) begin
      ang_d = 16'(AngleLimit);
    end else if (z_scaled < -(AngAccW-6)'(AngleLimit)) begin
      ang_d = -16'(AngleLimit);
    end else begin
      ang_d = 16'(z_scaled);
    end
  end

  logic [ProdLoW-1:0] prod_lo_q;
  logic [ProdHiW-1:0] prod_hi_q;
  logic signed [15:0] ang_q;
  logic               zero_p_q;

  always_ff @(posedge clk_i) begin
    if (valid_q[NumIter] && ready[ProdIdx]) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      ang_q     <= ang_d;
      zero_p_q  <= zero_q[NumIter];
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude sum, scale and clamp
  // --------------------------------------------------------------------------
  logic [SumW-1:0]          prod_sum;
  logic [SumW-MagShift-1:0] mag_full;
  logic [15:0]              mag_d;

  always_comb begin
    prod_sum = (SumW'(prod_hi_q) << SplitW) + SumW'(prod_lo_q);
    mag_full = prod_sum[SumW-1:MagShift];
    if (zero_p_q) begin
      mag_d = '0;
    end else if (mag_full > (SumW-MagShift)'(MagLimit)) begin
      mag_d = 16'(MagLimit);
    end else begin
      mag_d = mag_full[15:0];
    end
  end

  logic [15:0]        mag_q;
  logic signed [15:0] ang_out_q;

  always_ff @(posedge clk_i) begin
    if (valid_q[ProdIdx] && ready[OutIdx]) begin
      mag_q     <= mag_d;
      ang_out_q <= ang_q;
    end
  end

  assign out_valid_o = valid_q[OutIdx];
  assign magnitude_o = mag_q;
  assign angle_o     = ang_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input backpressure only arises with every stage full and the output stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q) && !out_ready_i)
    else $error("input stalled while the pipeline has a free slot");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> magnitude_o <= 16'(MagLimit))
    else $error("magnitude above limit");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angle_o <= 16'sd25736) && (angle_o >= -16'sd25736))
    else $error("angle outside +-pi");

  // A result taken under stall frees the output slot for the product stage
  a_out_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && valid_q[ProdIdx] |=> out_valid_o)
    else $error("output slot lost a pending transaction");

endmodule : stick_cartesian_to_polar

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stick cartesian-to-polar converter.
// ----------------------------------------------------------------------------
// Sends directed corner samples and then random stick samples through the
// valid/ready input channel. Random gaps are inserted on the sender side and
// random stalls on the receiver side, with one long receiver hold-off so the
// pipeline fills and stalls its input. Each accepted sample is converted by
// a bit-exact CORDIC vectoring model kept in this file. Every result
// transaction is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------

module tb_top;
  import stcp_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int Latency       = CORDIC_STAGES + 3;
  localparam int CycleLimit    = 200000;
  localparam int RandomItems   = 1930;
  localparam int CalmTail      = 150;
  localparam int LongHoldStart = 300;
  localparam int LongHoldLen   = 300;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_t;

  typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] angle;
  } polar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] x_coord_i   = '0;
  logic signed [15:0] y_coord_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [15:0] magnitude_o;
  logic signed [15:0] angle_o;

  stick_t samples_q[$];
  polar_t polar_q[$];

  int  cycle_cnt  = 0;
  int  err_cnt    = 0;
  int  n_taken    = 0;
  int  send_gap   = 0;
  int  recv_hold  = 0;
  bit  long_done  = 1'b0;
  bit  timed_out  = 1'b0;
  logic in_taken  = 1'b0;

  stick_cartesian_to_polar #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .magnitude_o(magnitude_o),
    .angle_o    (angle_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Fold into the right half plane, rotate y to zero, scale x by inverse gain.
  function automatic polar_t polar_of(logic signed [15:0] xi, logic signed [15:0] yi);
    longint xs, ys, x, y, z, dx, dy, comp, ang;
    longint unsigned prod;
    int     n;
    polar_t r;
    n  = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
    xs = xi;
    ys = yi;
    z  = 0;
    if (xs == 0 && ys == 0) begin
      r.magnitude = '0;
      r.angle     = '0;
      return r;
    end
    if (xs < 0) begin
      z  = (ys >= 0) ? longint'(PiQ20) : -longint'(PiQ20);
      xs = -xs;
      ys = -ys;
    end
    x = xs * (longint'(1) << GuardBits);
    y = ys * (longint'(1) << GuardBits);
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(AtanQ20[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(AtanQ20[i]);
      end
    end
    comp = longint'(InvGainQ30) + longint'(GainTailQ30 >> (2 * n));
    if (x < 0) x = 0;
    prod = (unsigned'(x) * unsigned'(comp)) >> MagShift;
    if (prod > MagLimit) prod = MagLimit;
    ang = (z + 64) >>> 7;
    if (ang > AngleLimit) ang = AngleLimit;
    if (ang < -AngleLimit) ang = -AngleLimit;
    r.magnitude = prod[15:0];
    r.angle     = ang[15:0];
    return r;
  endfunction

  task automatic add_sample(input int xv, input int yv);
    stick_t s;
    s.x = xv[15:0];
    s.y = yv[15:0];
    samples_q.push_back(s);
  endtask

  function automatic int rand_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_corner();
    int pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  // Sender: hold until accepted, then advance or insert a gap burst.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (samples_q.size() > CalmTail && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 5) - 1;
          in_valid_i <= 1'b0;
        end else if (samples_q.size() > 0) begin
          stick_t s;
          s = samples_q.pop_front();
          x_coord_i  <= s.x;
          y_coord_i  <= s.y;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: short stall bursts, plus one long hold-off to back up the pipe.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else if (!long_done && n_taken >= LongHoldStart) begin
        long_done = 1'b1;
        recv_hold = LongHoldLen - 1;
        out_ready_i <= 1'b0;
      end else if (samples_q.size() > CalmTail && $urandom_range(0, 5) == 0) begin
        recv_hold = $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check results first, then predict for the input transaction of this edge.
  always @(posedge clk_i) begin
    polar_t want;
    cycle_cnt++;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (polar_q.size() == 0) begin
        $error("unexpected result: magnitude %0d angle %0d", magnitude_o, angle_o);
        err_cnt++;
      end else begin
        want = polar_q.pop_front();
        if (magnitude_o !== want.magnitude) begin
          $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude_o);
          err_cnt++;
        end
        if (angle_o !== want.angle) begin
          $error("angle: expected %0d, actual %0d", want.angle, angle_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      polar_q.push_back(polar_of(x_coord_i, y_coord_i));
      n_taken++;
    end
  end

  initial begin
    int kind, a, b;

    // Origin, axes, half-plane fold and full-scale corners
    add_sample(0, 0);
    add_sample(1, 0);
    add_sample(-1, 0);
    add_sample(0, 1);
    add_sample(0, -1);
    add_sample(-32768, 0);
    add_sample(32767, 0);
    add_sample(0, 32767);
    add_sample(0, -32768);
    add_sample(32767, 32767);
    add_sample(-32768, -32768);
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    add_sample(-1, -1);
    add_sample(-1, 1);
    add_sample(1, -1);
    add_sample(1, 1);
    add_sample(-32768, -1);
    add_sample(-32768, 1);
    add_sample(-5, 0);
    add_sample(100, -100);

    for (int k = 0; k < RandomItems; k++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          a = rand_word();
          b = rand_word();
        end
        4, 5: begin
          a = int'($urandom_range(0, 128)) - 64;
          b = int'($urandom_range(0, 128)) - 64;
        end
        6: begin
          a = rand_word();
          b = 0;
          if ($urandom_range(0, 1)) begin
            b = a;
            a = 0;
          end
        end
        7: begin
          a = rand_word();
          b = $urandom_range(0, 1) ? a : -a;
        end
        8: begin
          a = rand_corner();
          b = rand_corner();
        end
        default: begin
          a = -int'($urandom_range(1, 32768));
          b = int'($urandom_range(0, 4)) - 2;
        end
      endcase
      add_sample(a, b);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    fork
      begin
        wait (samples_q.size() == 0 && !in_valid_i);
        wait (polar_q.size() == 0);
        repeat (2 * Latency) @(posedge clk_i);
      end
      begin
        wait (cycle_cnt >= CycleLimit);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && err_cnt == 0 && polar_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_top
